// ----- rtl/kcl_pkg.sv -----
// Shared types, constants and the key-to-symbol map for the keypad code lock.
package kcl_pkg;

  // Default values for the top-level parameters.
  localparam int NUM_KEYS_DEF     = 12;
  localparam int MAX_CODE_LEN_DEF = 16;

  // Fixed field widths.
  localparam int CODE_W      = 64;
  localparam int CODE_LEN_W  = 5;
  localparam int TIMEOUT_W   = 12;
  localparam int SYMBOL_W    = 4;
  localparam int COUNT_W     = 5;
  localparam int CFG_INDEX_W = 2;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 12'd60;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CODE_SYMBOLS  = 2'd0,
    REG_CODE_LENGTH   = 2'd1,
    REG_TIMEOUT_TICKS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CODE_W-1:0]     code_symbols;
    logic [CODE_LEN_W-1:0] code_length;
    logic [TIMEOUT_W-1:0]  timeout_ticks;
  } cfg_t;

  // A detected key press from the scanner.
  typedef struct packed {
    logic                valid;
    logic [SYMBOL_W-1:0] symbol;
  } press_t;

  // One result per sample tick.
  typedef struct packed {
    logic                key_valid;
    logic [SYMBOL_W-1:0] key_symbol;
    logic [COUNT_W-1:0]  entered_count;
    logic                code_match;
    logic                buffer_cleared;
  } result_t;

  // Keypad wiring: pin index to symbol (digits, then star as 10 and hash as 11).
  // Pins twelve and above map to their own index.
  function automatic logic [SYMBOL_W-1:0] pin_symbol(input logic [3:0] pin);
    logic [SYMBOL_W-1:0] sym;
    case (pin)
      4'd0:    sym = 4'd10;
      4'd1:    sym = 4'd7;
      4'd2:    sym = 4'd4;
      4'd3:    sym = 4'd1;
      4'd4:    sym = 4'd0;
      4'd5:    sym = 4'd8;
      4'd6:    sym = 4'd5;
      4'd7:    sym = 4'd2;
      4'd8:    sym = 4'd11;
      4'd9:    sym = 4'd9;
      4'd10:   sym = 4'd6;
      4'd11:   sym = 4'd3;
      4'd12:   sym = 4'd12;
      4'd13:   sym = 4'd13;
      4'd14:   sym = 4'd14;
      4'd15:   sym = 4'd15;
      default: sym = 4'd0;
    endcase
    return sym;
  endfunction

endpackage

// ----- rtl/kcl_cfg_regs.sv -----
// Configuration register bank of the keypad code lock.
module kcl_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kcl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kcl_pkg::CODE_W-1:0]      cfg_data,
  output kcl_pkg::cfg_t                   cfg
);

  kcl_pkg::cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  // Writes to an index outside the register list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.code_symbols  <= '0;
      regs.code_length   <= '0;
      regs.timeout_ticks <= kcl_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == kcl_pkg::REG_CODE_SYMBOLS) begin
        regs.code_symbols <= cfg_data;
      end
      if (cfg_index == kcl_pkg::REG_CODE_LENGTH) begin
        regs.code_length <= cfg_data[kcl_pkg::CODE_LEN_W-1:0];
      end
      if (cfg_index == kcl_pkg::REG_TIMEOUT_TICKS) begin
        regs.timeout_ticks <= cfg_data[kcl_pkg::TIMEOUT_W-1:0];
      end
    end
  end

endmodule

// ----- rtl/kcl_key_scan.sv -----
// Key press detector: new-edge detection, lowest-pin priority and symbol mapping.
module kcl_key_scan #(
  parameter int NUM_KEYS = kcl_pkg::NUM_KEYS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [NUM_KEYS-1:0] pins,
  output kcl_pkg::press_t     press
);

  localparam int KeyIdxW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [NUM_KEYS-1:0] held_keys;
  logic [NUM_KEYS-1:0] held_keys_next;
  logic [NUM_KEYS-1:0] fresh;
  logic [NUM_KEYS-1:0] first_hot;
  logic [KeyIdxW-1:0]  key_idx;

  assign fresh     = pins & ~held_keys;
  // Isolate the lowest set bit.
  assign first_hot = fresh & (~fresh + NUM_KEYS'(1));

  always_comb begin
    key_idx = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (first_hot[i]) begin
        key_idx = key_idx | KeyIdxW'(i);
      end
    end
  end

  // On a press, pins above the pressed one are forgotten so they can report
  // on a later tick.
  always_comb begin
    if (|fresh) begin
      held_keys_next = pins & (first_hot | (first_hot - NUM_KEYS'(1)));
    end else begin
      held_keys_next = pins;
    end
  end

  assign press.valid  = |fresh;
  assign press.symbol = (|fresh) ? kcl_pkg::pin_symbol(4'(key_idx)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_keys <= '0;
    end else if (advance) begin
      held_keys <= held_keys_next;
    end
  end

endmodule

// ----- rtl/kcl_entry_track.sv -----
// Entry sequence tracker: prefix compare against the code, count and idle timeout.
module kcl_entry_track #(
  parameter int MAX_CODE_LEN = kcl_pkg::MAX_CODE_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  kcl_pkg::press_t  press,
  input  kcl_pkg::cfg_t    cfg,
  output kcl_pkg::result_t result
);

  localparam logic [kcl_pkg::COUNT_W-1:0] MaxLen   = kcl_pkg::COUNT_W'(MAX_CODE_LEN);
  localparam logic [kcl_pkg::COUNT_W-1:0] CountSat = kcl_pkg::COUNT_W'(MAX_CODE_LEN + 1);

  logic [kcl_pkg::COUNT_W-1:0]   entry_count;
  logic [kcl_pkg::COUNT_W-1:0]   entry_count_next;
  logic                          prefix_ok;
  logic                          prefix_ok_next;
  logic [kcl_pkg::TIMEOUT_W-1:0] idle_ticks;
  logic [kcl_pkg::TIMEOUT_W-1:0] idle_ticks_next;
  logic [kcl_pkg::TIMEOUT_W-1:0] idle_inc;
  logic [kcl_pkg::SYMBOL_W-1:0]  want;
  logic                          len_ok;

  // Expected symbol at the current position; only used while the position
  // is below the maximum code length, so four index bits suffice.
  assign want     = cfg.code_symbols[{entry_count[3:0], 2'b00} +: kcl_pkg::SYMBOL_W];
  assign idle_inc = idle_ticks + kcl_pkg::TIMEOUT_W'(1);
  assign len_ok   = (cfg.code_length != '0) && (cfg.code_length <= MaxLen);

  always_comb begin
    entry_count_next      = entry_count;
    prefix_ok_next        = prefix_ok;
    idle_ticks_next       = idle_ticks;
    result.key_valid      = press.valid;
    result.key_symbol     = press.symbol;
    result.code_match     = 1'b0;
    result.buffer_cleared = 1'b0;
    if (press.valid) begin
      prefix_ok_next = prefix_ok && (entry_count < MaxLen) && (want == press.symbol);
      if (entry_count < CountSat) begin
        entry_count_next = entry_count + kcl_pkg::COUNT_W'(1);
      end
      result.code_match = prefix_ok_next && len_ok && (entry_count_next == cfg.code_length);
      idle_ticks_next   = '0;
    end else if (idle_ticks < cfg.timeout_ticks) begin
      idle_ticks_next = idle_inc;
      if (idle_inc == cfg.timeout_ticks) begin
        entry_count_next      = '0;
        prefix_ok_next        = 1'b1;
        result.buffer_cleared = 1'b1;
      end
    end
    result.entered_count = entry_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      prefix_ok   <= 1'b1;
      idle_ticks  <= '0;
    end else if (advance) begin
      entry_count <= entry_count_next;
      prefix_ok   <= prefix_ok_next;
      idle_ticks  <= idle_ticks_next;
    end
  end

endmodule

// ----- rtl/keypad_code_lock_core.sv -----
// Keypad code lock: top level with input register, press logic and result register.
//
// Each input request on the pin channel (in_valid, in_stall, pin_levels) is one
// sample tick of the keypad pins. Every accepted request yields exactly one
// result request on the output channel (out_valid, out_stall and the five
// result fields), in order.
// A request accepted into the input register passes the press logic
// combinationally and is loaded into the result register once that register
// is empty or its current result is being taken.
// Throughput: one request per cycle unless the receiver stalls, set by the single
// registered pass through the press detector and entry tracker; the only feedback
// is the held-key, count, prefix and idle state, all updated in that same cycle.
// When the receiver stalls, the result register holds its request and the
// input register still takes one more request; after that in_stall rises
// until the result is taken.
// Configuration is written through cfg_valid/cfg_ready/cfg_index/cfg_data,
// always ready. The user must write it only while no request is in flight; the
// block does not enforce this. Indexes outside the three registers are ignored.
// Synchronous reset empties both registers, clears the held keys and the
// entry state, and loads the code registers with zero and the timeout with 60.
module keypad_code_lock_core #(
  parameter int NUM_KEYS     = kcl_pkg::NUM_KEYS_DEF,
  parameter int MAX_CODE_LEN = kcl_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Pin sample channel.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [NUM_KEYS-1:0]             pin_levels,
  // Result channel.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            key_valid,
  output logic [kcl_pkg::SYMBOL_W-1:0]    key_symbol,
  output logic [kcl_pkg::COUNT_W-1:0]     entered_count,
  output logic                            code_match,
  output logic                            buffer_cleared,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kcl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kcl_pkg::CODE_W-1:0]      cfg_data
);

  kcl_pkg::cfg_t    cfg;
  kcl_pkg::press_t  press;
  kcl_pkg::result_t step_result;
  kcl_pkg::result_t out_result;

  logic                pipe_valid;
  logic [NUM_KEYS-1:0] pipe_pins;
  logic                advance;

  // The registered sample moves on whenever the result register is empty or
  // its current request is being taken in this cycle.
  assign advance  = pipe_valid && (!out_valid || !out_stall);
  assign in_stall = pipe_valid && !advance;

  kcl_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kcl_key_scan #(
    .NUM_KEYS (NUM_KEYS)
  ) u_key_scan (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .pins    (pipe_pins),
    .press   (press)
  );

  kcl_entry_track #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_entry_track (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .press   (press),
    .cfg     (cfg),
    .result  (step_result)
  );

  // Input register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (!in_stall) begin
      pipe_valid <= in_valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      pipe_pins <= pin_levels;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= pipe_valid;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign key_valid      = out_result.key_valid;
  assign key_symbol     = out_result.key_symbol;
  assign entered_count  = out_result.entered_count;
  assign code_match     = out_result.code_match;
  assign buffer_cleared = out_result.buffer_cleared;

  // A match can only come with a press.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!code_match || key_valid))
    else $error("code match reported without a key press");

  // A timeout clear happens only on an idle tick and leaves an empty sequence.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && buffer_cleared) |-> (!key_valid && entered_count == '0))
    else $error("timeout clear with a press or a non-empty sequence");

  // The entered count never passes its saturation value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entered_count <= kcl_pkg::COUNT_W'(MAX_CODE_LEN + 1)))
    else $error("entered count beyond saturation");

  // The input side is held back only while a finished result waits.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && pipe_valid))
    else $error("input stalled without a waiting result");

endmodule
